[rtl/tpt_pkg.sv]
// Shared constants for the trapezoid profile timing block.
`timescale 1ns / 1ps
package tpt_pkg;
  // Default value width and fraction bits (Q16.16).
  localparam int VALUE_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;
endpackage

[rtl/tpt_div.sv]
// Pipelined restoring divider with a saturating quotient, one quotient bit per stage.
`timescale 1ns / 1ps
module tpt_div #(
  parameter int NW = 48,
  parameter int DW = 32,
  parameter int QW = 32
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo
);
  localparam int HW = NW - QW;
  localparam int CW = (HW > DW) ? HW : DW;

  logic [DW-1:0] rem_r [0:QW];
  logic [DW-1:0] den_r [0:QW];
  logic [QW-1:0] low_r [0:QW];
  logic [QW-1:0] q_r   [0:QW];
  logic          sat_r [0:QW];

  logic [HW-1:0] hi;
  assign hi = num[NW-1:QW];

  // Load: saturate when the quotient cannot fit QW bits
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= DW'(hi);
      den_r[0] <= den;
      low_r[0] <= num[QW-1:0];
      q_r[0]   <= '0;
      sat_r[0] <= (CW'(hi) >= CW'(den));
    end
  end

  // One subtract-and-compare per stage
  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DW:0] t;
    logic [DW:0] dx;
    logic        ge;
    assign t  = {rem_r[k], low_r[k][QW-1]};
    assign dx = {1'b0, den_r[k]};
    assign ge = (t >= dx);
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1] <= ge ? DW'(t - dx) : DW'(t);
        den_r[k+1] <= den_r[k];
        low_r[k+1] <= {low_r[k][QW-2:0], 1'b0};
        q_r[k+1]   <= {q_r[k][QW-2:0], ge};
        sat_r[k+1] <= sat_r[k];
      end
    end
  end

  assign quo = sat_r[QW] ? '1 : q_r[QW];
endmodule

[rtl/trapezoid_profile_times_top.sv]
// Top level: pipelined trapezoid profile timing for one motion segment per beat.
`timescale 1ns / 1ps
// Usage:
//   Input channel in_*: one motion segment per beat (entry, max entry, exit,
//   target rate, acceleration, length), unsigned fixed point.
//   Output channel out_*: ramp up, hold and ramp down times, peak speed and
//   a fault flag for a zero acceleration or zero target rate.
//   Datapath: each beat passes through the square root stages (one root bit
//   each) followed by the divider stages (one quotient bit each).
//   Throughput: one beat per cycle while the receiver takes results.
//   Stall: when out_stall holds a waiting result, the whole pipeline freezes
//   and in_stall rises in the same cycle; no beat is lost or repeated.
//   Reset: rst_n clears all valid bits; the pipeline comes up empty.
module trapezoid_profile_times_top #(
  parameter int VALUE_WIDTH = tpt_pkg::VALUE_WIDTH_DEF,
  parameter int FRAC_BITS   = tpt_pkg::FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [VALUE_WIDTH-1:0] in_entry_speed,
  input  logic [VALUE_WIDTH-1:0] in_max_entry_limit,
  input  logic [VALUE_WIDTH-1:0] in_exit_speed,
  input  logic [VALUE_WIDTH-1:0] in_target_rate,
  input  logic [VALUE_WIDTH-1:0] in_accel_rate,
  input  logic [VALUE_WIDTH-1:0] in_seg_length,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [VALUE_WIDTH-1:0] out_ramp_up_time,
  output logic [VALUE_WIDTH-1:0] out_hold_time,
  output logic [VALUE_WIDTH-1:0] out_ramp_down_time,
  output logic [VALUE_WIDTH-1:0] out_peak_speed,
  output logic                   out_div_fault
);
  localparam int W   = VALUE_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int W2  = 2 * W;
  localparam int RW  = W + 1;
  localparam int HNW = W2 + 2 + F;

  typedef struct packed {
    logic [W-1:0]    vi;
    logic [W-1:0]    ve;
    logic [W-1:0]    vp;
    logic [W-1:0]    a;
    logic            atmax;
    logic            is_tri;
    logic            a_zero;
    logic            vp_zero;
    logic [W2+1:0]   hnum;
    logic [W2:0]     hden;
  } sq_side_t;

  typedef struct packed {
    logic [W-1:0] peak;
    logic         is_tri;
    logic         a_zero;
    logic         vp_zero;
  } dv_side_t;

  logic out_valid_r;
  logic en;
  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  // Stage 1: products
  logic          s1_v_r;
  logic [W2-1:0] s1_sqi_r, s1_sqe_r, s1_sqp_r, s1_ad_r, s1_avp_r;
  logic [W-1:0]  s1_vi_r, s1_ve_r, s1_vp_r, s1_a_r;
  logic          s1_atmax_r, s1_az_r, s1_vz_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_sqi_r   <= W2'(in_entry_speed) * W2'(in_entry_speed);
      s1_sqe_r   <= W2'(in_exit_speed) * W2'(in_exit_speed);
      s1_sqp_r   <= W2'(in_target_rate) * W2'(in_target_rate);
      s1_ad_r    <= W2'(in_accel_rate) * W2'(in_seg_length);
      s1_avp_r   <= W2'(in_accel_rate) * W2'(in_target_rate);
      s1_vi_r    <= in_entry_speed;
      s1_ve_r    <= in_exit_speed;
      s1_vp_r    <= in_target_rate;
      s1_a_r     <= in_accel_rate;
      s1_atmax_r <= (in_entry_speed == in_max_entry_limit);
      s1_az_r    <= (in_accel_rate == '0);
      s1_vz_r    <= (in_target_rate == '0);
    end
  end

  // Stage 2: select the speed-squared terms and add the length term
  logic          s2_v_r;
  logic [W2:0]   s2_pos_r, s2_hden_r;
  logic [W2+1:0] s2_lhs_r;
  logic [W-1:0]  s2_vi_r, s2_ve_r, s2_vp_r, s2_a_r;
  logic          s2_atmax_r, s2_az_r, s2_vz_r;
  logic [W2:0]   s2_pos_nxt, s2_neg_nxt;

  always_comb begin
    if (s1_atmax_r) begin
      s2_pos_nxt = {1'b0, s1_sqi_r};
      s2_neg_nxt = {1'b0, s1_sqe_r};
    end else begin
      s2_pos_nxt = {s1_sqp_r, 1'b0};
      s2_neg_nxt = {1'b0, s1_sqi_r} + {1'b0, s1_sqe_r};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_pos_r   <= s2_pos_nxt;
      s2_lhs_r   <= {1'b0, s1_ad_r, 1'b0} + {1'b0, s2_neg_nxt};
      s2_hden_r  <= {s1_avp_r, 1'b0};
      s2_vi_r    <= s1_vi_r;
      s2_ve_r    <= s1_ve_r;
      s2_vp_r    <= s1_vp_r;
      s2_a_r     <= s1_a_r;
      s2_atmax_r <= s1_atmax_r;
      s2_az_r    <= s1_az_r;
      s2_vz_r    <= s1_vz_r;
    end
  end

  // Stage 3: triangle test, hold numerator, root radicand
  logic          sq_v_r    [0:W];
  logic [RW-1:0] sq_rem_r  [0:W];
  logic [W-1:0]  sq_root_r [0:W];
  logic [W2-1:0] sq_x_r    [0:W];
  sq_side_t      sq_side_r [0:W];
  logic          s3_gt;
  sq_side_t      s3_side;

  always_comb begin
    s3_gt          = ({1'b0, s2_pos_r} > s2_lhs_r);
    s3_side.vi     = s2_vi_r;
    s3_side.ve     = s2_ve_r;
    s3_side.vp     = s2_vp_r;
    s3_side.a      = s2_a_r;
    s3_side.atmax  = s2_atmax_r;
    s3_side.is_tri = !s2_atmax_r && !s2_az_r && s3_gt;
    s3_side.a_zero = s2_az_r;
    s3_side.vp_zero = s2_vz_r;
    s3_side.hnum   = s3_gt ? ({1'b0, s2_pos_r} - s2_lhs_r) : (s2_lhs_r - {1'b0, s2_pos_r});
    s3_side.hden   = s2_hden_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_rem_r[0]  <= '0;
      sq_root_r[0] <= '0;
      sq_x_r[0]    <= s2_lhs_r[W2:1];
      sq_side_r[0] <= s3_side;
    end
  end

  // Square root stages: one root bit each
  for (genvar j = 0; j < W; j++) begin : g_sqrt
    logic [RW+1:0] t;
    logic [RW+1:0] trial;
    logic          ge;
    assign t     = {sq_rem_r[j], sq_x_r[j][W2-1:W2-2]};
    assign trial = (RW+2)'({sq_root_r[j], 2'b01});
    assign ge    = (t >= trial);
    always_ff @(posedge clk) begin
      if (en) begin
        sq_rem_r[j+1]  <= ge ? RW'(t - trial) : RW'(t);
        sq_root_r[j+1] <= {sq_root_r[j][W-2:0], ge};
        sq_x_r[j+1]    <= {sq_x_r[j][W2-3:0], 2'b00};
        sq_side_r[j+1] <= sq_side_r[j];
      end
    end
  end

  // Stage 4: pick the peak speed and the speed changes
  sq_side_t     s4_in;
  logic [W-1:0] s4_peak_nxt;
  logic         s4_v_r;
  logic [W-1:0] s4_dup_r, s4_ddn_r, s4_a_r;
  logic [HNW-1:0] s4_hnum_r;
  logic [W2:0]  s4_hden_r;
  dv_side_t     s4_side_r;

  assign s4_in = sq_side_r[W];
  always_comb begin
    if (s4_in.atmax) begin
      s4_peak_nxt = s4_in.vi;
    end else if (s4_in.is_tri) begin
      s4_peak_nxt = sq_root_r[W];
    end else begin
      s4_peak_nxt = s4_in.vp;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_dup_r  <= (s4_peak_nxt > s4_in.vi) ? s4_peak_nxt - s4_in.vi : s4_in.vi - s4_peak_nxt;
      s4_ddn_r  <= (s4_peak_nxt > s4_in.ve) ? s4_peak_nxt - s4_in.ve : s4_in.ve - s4_peak_nxt;
      s4_a_r    <= s4_in.a;
      s4_hnum_r <= {s4_in.hnum, {F{1'b0}}};
      s4_hden_r <= s4_in.hden;
      s4_side_r.peak    <= s4_peak_nxt;
      s4_side_r.is_tri  <= s4_in.is_tri;
      s4_side_r.a_zero  <= s4_in.a_zero;
      s4_side_r.vp_zero <= s4_in.vp_zero;
    end
  end

  // Dividers
  logic [W-1:0] q_up, q_dn, q_hold;

  tpt_div #(.NW(W + F), .DW(W), .QW(W)) u_div_up (
    .clk(clk), .en(en), .num({s4_dup_r, {F{1'b0}}}), .den(s4_a_r), .quo(q_up)
  );
  tpt_div #(.NW(W + F), .DW(W), .QW(W)) u_div_dn (
    .clk(clk), .en(en), .num({s4_ddn_r, {F{1'b0}}}), .den(s4_a_r), .quo(q_dn)
  );
  tpt_div #(.NW(HNW), .DW(W2 + 1), .QW(W)) u_div_hold (
    .clk(clk), .en(en), .num(s4_hnum_r), .den(s4_hden_r), .quo(q_hold)
  );

  // Side data aligned with the divider stages
  dv_side_t dv_side_r [0:W];
  logic     dv_v_r    [0:W];

  always_ff @(posedge clk) begin
    if (en) begin
      dv_side_r[0] <= s4_side_r;
    end
  end
  for (genvar k = 0; k < W; k++) begin : g_dvside
    always_ff @(posedge clk) begin
      if (en) begin
        dv_side_r[k+1] <= dv_side_r[k];
      end
    end
  end

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      for (int i = 0; i <= W; i++) begin
        sq_v_r[i] <= 1'b0;
        dv_v_r[i] <= 1'b0;
      end
    end else if (en) begin
      s1_v_r    <= in_valid;
      s2_v_r    <= s1_v_r;
      sq_v_r[0] <= s2_v_r;
      for (int i = 0; i < W; i++) begin
        sq_v_r[i+1] <= sq_v_r[i];
        dv_v_r[i+1] <= dv_v_r[i];
      end
      s4_v_r    <= sq_v_r[W];
      dv_v_r[0] <= s4_v_r;
    end
  end

  // Output register: apply fault overrides
  logic [W-1:0] out_up_r, out_hold_r, out_dn_r, out_peak_r;
  logic         out_fault_r;
  dv_side_t     fin;
  assign fin = dv_side_r[W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_v_r[W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_up_r    <= fin.a_zero ? '1 : q_up;
      out_dn_r    <= fin.a_zero ? '1 : q_dn;
      out_hold_r  <= (fin.a_zero || fin.vp_zero) ? '1 : (fin.is_tri ? '0 : q_hold);
      out_peak_r  <= fin.peak;
      out_fault_r <= fin.a_zero || fin.vp_zero;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_ramp_up_time   = out_up_r;
  assign out_hold_time      = out_hold_r;
  assign out_ramp_down_time = out_dn_r;
  assign out_peak_speed     = out_peak_r;
  assign out_div_fault      = out_fault_r;
endmodule
